[src/glp_pkg.sv]
// ----------------------------------------------------------------------------
// glp_pkg
// Shared constants, codes and types of the line glob pattern matcher.
// ----------------------------------------------------------------------------
package glp_pkg;

  // Pattern size and index widths
  localparam int MAX_ELEMENTS = 32;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int FIELD_IDX_W  = 5;
  localparam int CMP_W        = ((IDX_W > FIELD_IDX_W) ? IDX_W : FIELD_IDX_W) + 1;

  // Field widths
  localparam int CHAR_W    = 8;
  localparam int SET_W     = 64;
  localparam int KIND_W    = 2;
  localparam int ACTION_W  = 2;
  localparam int OFF_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [OFF_W-1:0]        OFF_MAX   = {OFF_W{1'b1}};
  localparam logic [CHAR_W-1:0]       EOL_RESET = 8'd10;
  localparam logic [MAX_ELEMENTS-1:0] POS_RESET = {{(MAX_ELEMENTS-1){1'b0}}, 1'b1};

  // Word actions
  typedef enum logic [ACTION_W-1:0] {
    ACT_ELEM = 2'd0,
    ACT_HIGH = 2'd1,
    ACT_TEXT = 2'd2,
    ACT_NONE = 2'd3
  } glp_action_t;

  // Element kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_EXACT = 2'd0,
    KIND_ANY   = 2'd1,
    KIND_SET   = 2'd2,
    KIND_STAR  = 2'd3
  } glp_kind_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EOL  = 1'b0,
    CFG_LAST = 1'b1
  } glp_cfg_idx_t;

  // Per-cell control from the top level
  typedef struct packed {
    logic ld_lo;   // load kind, char and low set half
    logic ld_hi;   // load high set half
    logic en;      // cell lies before the final element
  } glp_cell_ctl_t;

  // Element load data broadcast to all cells
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] chr;
    logic [SET_W-1:0]  set_bits;
  } glp_load_t;

  // One result word
  typedef struct packed {
    logic [OFF_W-1:0] line_start;
    logic [OFF_W-1:0] line_end;
  } glp_res_t;

  // Saturating offset increment
  function automatic logic [OFF_W-1:0] sat_inc(input logic [OFF_W-1:0] v);
    return (v == OFF_MAX) ? v : v + 1'b1;
  endfunction

endpackage

[src/glp_if.sv]
// ----------------------------------------------------------------------------
// glp interfaces
// Valid/ready channels for input words, result words and register writes.
// ----------------------------------------------------------------------------
interface glp_item_if;
  import glp_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [ACTION_W-1:0]    action;
  logic [FIELD_IDX_W-1:0] elem_index;
  logic [KIND_W-1:0]      elem_kind;
  logic [CHAR_W-1:0]      elem_char;
  logic [SET_W-1:0]       set_bits;
  logic [CHAR_W-1:0]      text_char;
  logic                   buffer_start;

  modport source (output valid, action, elem_index, elem_kind, elem_char, set_bits,
                  text_char, buffer_start, input ready);
  modport sink (input valid, action, elem_index, elem_kind, elem_char, set_bits,
                text_char, buffer_start, output ready);
endinterface

interface glp_result_if;
  import glp_pkg::*;
  logic             valid;
  logic             ready;
  logic [OFF_W-1:0] line_start;
  logic [OFF_W-1:0] line_end;

  modport source (output valid, line_start, line_end, input ready);
  modport sink (input valid, line_start, line_end, output ready);
endinterface

interface glp_cfg_if;
  import glp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/glp_cell.sv]
// ----------------------------------------------------------------------------
// glp_cell
// One pattern element: holds its kind, character and set, and advances
// its position bit for each text character.
// ----------------------------------------------------------------------------
module glp_cell (
  input  logic                  clk,
  input  glp_pkg::glp_cell_ctl_t ctl,
  input  glp_pkg::glp_load_t    ld,
  input  logic [7:0]            text_char,
  input  logic                  active,     // position bit before star closure
  input  logic                  carry_in,   // star skip from the left neighbour
  input  logic                  step_in,    // match hand-over from the left neighbour
  output logic                  closed,     // position bit after star closure
  output logic                  carry_out,
  output logic                  step_out,
  output logic                  next_active
);
  import glp_pkg::*;

  logic [KIND_W-1:0] kind;
  logic [CHAR_W-1:0] chr;
  logic [SET_W-1:0]  set_lo;
  logic [SET_W-1:0]  set_hi;
  logic              in_set;
  logic              ok;
  logic              star;

  // Element store, undefined until loaded
  always_ff @(posedge clk) begin
    if (ctl.ld_lo) begin
      kind   <= ld.kind;
      chr    <= ld.chr;
      set_lo <= ld.set_bits;
    end
    if (ctl.ld_hi) begin
      set_hi <= ld.set_bits;
    end
  end

  // Set lookup on the low 7 bits
  assign in_set = text_char[6] ? set_hi[text_char[5:0]] : set_lo[text_char[5:0]];

  always_comb begin
    case (kind)
      KIND_EXACT: ok = (text_char == chr);
      KIND_ANY:   ok = 1'b1;
      KIND_SET:   ok = in_set;
      default:    ok = 1'b0;
    endcase
  end

  assign star        = (kind == KIND_STAR);
  assign closed      = active | carry_in;
  assign carry_out   = closed & ctl.en & star;
  assign step_out    = closed & ctl.en & ok;
  assign next_active = step_in | carry_out;

endmodule

[src/line_glob_pattern_matcher_core.sv]
// ----------------------------------------------------------------------------
// line_glob_pattern_matcher_core
// Whole-line glob matcher: a row of element cells advances the active
// position vector by one text character per word.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while the result buffer has room; every word is handled in the
//   cycle it is accepted, the star skip rippling through the cell row like a carry.
// A result word is registered into the output buffer when its end-of-line word is taken.
// Results queue in a two-word output buffer; input stalls when it is full or in reset.
// Reset: position zero active, offsets zero, eol_char 10, pattern_last 0, no word taken;
//   element stores are not cleared and hold nothing until loaded.
module line_glob_pattern_matcher_core (
  input  logic clk,
  input  logic rst,
  glp_item_if.sink     item,
  glp_result_if.source result,
  glp_cfg_if.sink      cfg
);
  import glp_pkg::*;

  // Registers
  logic [CHAR_W-1:0]       eol_char;
  logic [FIELD_IDX_W-1:0]  pattern_last;
  logic [MAX_ELEMENTS-1:0] active;
  logic [OFF_W-1:0]        text_offset;
  logic [OFF_W-1:0]        line_start_q;
  glp_res_t                q0, q1, q0_next, q1_next;
  logic                    v0, v1, v0_next, v1_next;

  // Working signals
  logic                    acc;
  logic                    text_acc;
  logic                    idx_ok;
  logic [CMP_W-1:0]        idx_wide;
  logic [CMP_W-1:0]        last_wide;
  logic [IDX_W-1:0]        last_eff;
  logic [MAX_ELEMENTS-1:0] act_base;
  logic [MAX_ELEMENTS-1:0] closed;
  logic [MAX_ELEMENTS-1:0] next_vec;
  logic [MAX_ELEMENTS:0]   carry;
  logic [MAX_ELEMENTS:0]   step;
  logic [OFF_W-1:0]        off_base;
  logic [OFF_W-1:0]        ls_base;
  logic [OFF_W-1:0]        off_inc;
  logic                    is_eol;
  logic                    hit;
  logic                    push;
  logic                    pop;
  glp_res_t                new_res;
  glp_load_t               ld;

  // Handshake, held off while in reset
  assign item.ready = !v1 && !rst;
  assign cfg.ready  = !rst;
  assign acc        = item.valid & item.ready;
  assign text_acc   = acc & (item.action == ACT_TEXT);

  // Pattern bounds
  assign idx_wide  = CMP_W'(item.elem_index);
  assign idx_ok    = idx_wide < CMP_W'(MAX_ELEMENTS);
  assign last_wide = CMP_W'(pattern_last);
  assign last_eff  = (last_wide > CMP_W'(MAX_ELEMENTS - 1)) ? IDX_W'(MAX_ELEMENTS - 1)
                                                            : IDX_W'(last_wide);

  // Buffer start restarts before the character is taken
  assign act_base = item.buffer_start ? POS_RESET : active;
  assign off_base = item.buffer_start ? '0 : text_offset;
  assign ls_base  = item.buffer_start ? '0 : line_start_q;
  assign off_inc  = sat_inc(off_base);

  assign ld.kind     = item.elem_kind;
  assign ld.chr      = item.elem_char;
  assign ld.set_bits = item.set_bits;

  // Cell row
  assign carry[0] = 1'b0;
  assign step[0]  = 1'b0;

  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    glp_cell_ctl_t ctl;
    assign ctl.ld_lo = acc & (item.action == ACT_ELEM) & idx_ok & (idx_wide == CMP_W'(i));
    assign ctl.ld_hi = acc & (item.action == ACT_HIGH) & idx_ok & (idx_wide == CMP_W'(i));
    assign ctl.en    = CMP_W'(i) < CMP_W'(last_eff);

    glp_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .ld          (ld),
      .text_char   (item.text_char),
      .active      (act_base[i]),
      .carry_in    (carry[i]),
      .step_in     (step[i]),
      .closed      (closed[i]),
      .carry_out   (carry[i+1]),
      .step_out    (step[i+1]),
      .next_active (next_vec[i])
    );
  end

  // Line end check
  assign is_eol = (item.text_char == eol_char);
  assign hit    = closed[last_eff];
  assign push   = text_acc & is_eol & hit;
  assign pop    = v0 & result.ready;

  assign new_res.line_start = ls_base;
  assign new_res.line_end   = off_inc;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      eol_char     <= EOL_RESET;
      pattern_last <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_EOL:  eol_char     <= cfg.data;
        CFG_LAST: pattern_last <= cfg.data[FIELD_IDX_W-1:0];
        default:  ;
      endcase
    end
  end

  // Matching state
  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= POS_RESET;
      text_offset  <= '0;
      line_start_q <= '0;
    end else if (text_acc) begin
      text_offset <= off_inc;
      if (is_eol) begin
        active       <= POS_RESET;
        line_start_q <= off_inc;
      end else begin
        active       <= next_vec;
        line_start_q <= ls_base;
      end
    end
  end

  // Two-word result buffer
  always_comb begin
    q0_next = q0;
    q1_next = q1;
    v0_next = v0;
    v1_next = v1;
    if (pop) begin
      q0_next = q1;
      v0_next = v1;
      v1_next = 1'b0;
    end
    if (push) begin
      if (!v0_next) begin
        q0_next = new_res;
        v0_next = 1'b1;
      end else begin
        q1_next = new_res;
        v1_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      v0 <= v0_next;
      v1 <= v1_next;
    end
  end

  always_ff @(posedge clk) begin
    q0 <= q0_next;
    q1 <= q1_next;
  end

  assign result.valid      = v0;
  assign result.line_start = q0.line_start;
  assign result.line_end   = q0.line_end;

  // Checks
  a_buf_order: assert property (@(posedge clk) disable iff (rst) v1 |-> v0)
    else $error("result buffer tail valid without head");

  a_eol_restart: assert property (@(posedge clk) disable iff (rst)
    (text_acc && is_eol) |=> (active == POS_RESET))
    else $error("position vector not restarted after end-of-line");

  a_line_order: assert property (@(posedge clk) disable iff (rst)
    line_start_q <= text_offset)
    else $error("line start past text offset");

  a_row_end: assert property (@(posedge clk) disable iff (rst)
    !carry[MAX_ELEMENTS] && !step[MAX_ELEMENTS])
    else $error("activity past the end of the cell row");

  a_res_order: assert property (@(posedge clk) disable iff (rst)
    v0 |-> (q0.line_end >= q0.line_start))
    else $error("result line end before line start");

endmodule
